/* src/pgalloc_pkg.sv */
// ----------------------------------------------------------------------------
// pgalloc_pkg
// Shared codes and controller/datapath interface types of the page allocator.
// ----------------------------------------------------------------------------
package pgalloc_pkg;

  // command codes
  localparam logic [1:0] CMD_ALLOC  = 2'd0;
  localparam logic [1:0] CMD_FREE   = 2'd1;
  localparam logic [1:0] CMD_INCREF = 2'd2;
  localparam logic [1:0] CMD_QUERY  = 2'd3;

  // result status codes
  localparam logic [2:0] ST_OK        = 3'd0;
  localparam logic [2:0] ST_EMPTY     = 3'd1;
  localparam logic [2:0] ST_BADADDR   = 3'd2;
  localparam logic [2:0] ST_UNDERFLOW = 3'd3;
  localparam logic [2:0] ST_SATURATED = 3'd4;

  // configuration register indexes
  localparam int unsigned CFG_IDX_W = 2;
  localparam logic [CFG_IDX_W-1:0] REG_BASE  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_TOP   = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_FIRST = 2'd2;

  // configuration reset values
  localparam logic [31:0] BASE_RST  = 32'h8000_0000;
  localparam logic [31:0] TOP_RST   = 32'h8800_0000;
  localparam logic [31:0] FIRST_RST = 32'h8000_0000;

  // controller to datapath commands
  typedef struct packed {
    logic clr_en;   // write zero into the count table at the sweep pointer
    logic load;     // capture a new transaction
    logic decode;   // address checks, memory reads
    logic exec;     // update state, load result registers
  } pga_cmd_t;

  // datapath to controller status
  typedef struct packed {
    logic clr_last; // sweep pointer at the last entry
  } pga_sts_t;

endpackage

/* src/page_allocator_with_refcounts_core.sv */
// ----------------------------------------------------------------------------
// page_allocator_with_refcounts_core
// Page-frame allocator with a LIFO free stack and per-page reference counts.
// ----------------------------------------------------------------------------
//
//  channel | ports                                        | handshake
//  --------+----------------------------------------------+---------------------
//  input   | in_command, in_page_address                  | start && !busy
//  result  | out_status, out_granted_address,             | out_valid, 1 cycle
//          | out_reference_count, out_page_released       |
//  config  | cfg_we, cfg_index, cfg_wdata                 | cfg_we, no wait
//
//  each transaction runs through accept, decode (address checks and
//  registered reads of count table and free stack top), execute (write-back)
//  the result strobes in the cycle after execute; busy is low then, so the
//  next transaction can be accepted in that same cycle
//  after reset the count table is swept to zero, one entry a cycle, so busy
//  stays high until the last entry is cleared; config writes are taken during the sweep
//  the receiver cannot stall: each result is shown for exactly one cycle
//
module page_allocator_with_refcounts_core
  import pgalloc_pkg::*;
#(
  parameter int unsigned NUM_PAGES  = 32768,
  parameter int unsigned PAGE_SHIFT = 12,
  parameter int unsigned COUNT_BITS = 8
) (
  input  logic                 clk,
  input  logic                 rst_n,
  // input transactions
  input  logic                 start,
  output logic                 busy,
  input  logic [1:0]           in_command,
  input  logic [31:0]          in_page_address,
  // results
  output logic                 out_valid,
  output logic [2:0]           out_status,
  output logic [31:0]          out_granted_address,
  output logic [7:0]           out_reference_count,
  output logic                 out_page_released,
  // configuration writes
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [31:0]          cfg_wdata
);

  // command and status between sequencer and datapath
  pga_cmd_t cmd;
  pga_sts_t sts;

  // sequencer: sweep, then idle / decode / execute
  pgalloc_ctrl u_ctrl (
    .clk   (clk),
    .rst_n (rst_n),
    .start (start),
    .busy  (busy),
    .sts   (sts),
    .cmd   (cmd)
  );

  // datapath: count table and free stack live here, together with the
  // config registers and the result registers
  pgalloc_dp #(
    .NUM_PAGES  (NUM_PAGES),
    .PAGE_SHIFT (PAGE_SHIFT),
    .COUNT_BITS (COUNT_BITS)
  ) u_dp (
    .clk                 (clk),
    .rst_n               (rst_n),
    .cmd                 (cmd),
    .sts                 (sts),
    .cfg_we              (cfg_we),
    .cfg_index           (cfg_index),
    .cfg_wdata           (cfg_wdata),
    .in_command          (in_command),
    .in_page_address     (in_page_address),
    .out_valid           (out_valid),
    .out_status          (out_status),
    .out_granted_address (out_granted_address),
    .out_reference_count (out_reference_count),
    .out_page_released   (out_page_released)
  );

endmodule

/* src/pgalloc_ctrl.sv */
// ----------------------------------------------------------------------------
// pgalloc_ctrl
// Sequencer: clearing pass after reset, then accept / decode / execute.
// ----------------------------------------------------------------------------
module pgalloc_ctrl
  import pgalloc_pkg::*;
(
  input  logic     clk,
  input  logic     rst_n,
  input  logic     start,
  output logic     busy,
  input  pga_sts_t sts,
  output pga_cmd_t cmd
);

  typedef enum logic [3:0] {
    S_CLEAR  = 4'b0001,
    S_IDLE   = 4'b0010,
    S_DECODE = 4'b0100,
    S_EXEC   = 4'b1000
  } state_t;

  state_t state_r, state_nxt;

  always_comb begin
    state_nxt  = state_r;
    cmd        = '0;
    busy       = 1'b1;
    case (state_r)
      S_CLEAR: begin
        cmd.clr_en = 1'b1;
        if (sts.clr_last) begin
          state_nxt = S_IDLE;
        end
      end
      S_IDLE: begin
        busy = 1'b0;
        if (start) begin
          cmd.load  = 1'b1;
          state_nxt = S_DECODE;
        end
      end
      S_DECODE: begin
        cmd.decode = 1'b1;
        state_nxt  = S_EXEC;
      end
      S_EXEC: begin
        cmd.exec  = 1'b1;
        state_nxt = S_IDLE;
      end
      default: begin
        state_nxt = S_CLEAR;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_CLEAR;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule

/* src/pgalloc_dp.sv */
// ----------------------------------------------------------------------------
// pgalloc_dp
// Datapath: config registers, count table, free stack, result registers.
// ----------------------------------------------------------------------------
module pgalloc_dp
  import pgalloc_pkg::*;
#(
  parameter int unsigned NUM_PAGES  = 32768,
  parameter int unsigned PAGE_SHIFT = 12,
  parameter int unsigned COUNT_BITS = 8
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  pga_cmd_t             cmd,
  output pga_sts_t             sts,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [31:0]          cfg_wdata,
  input  logic [1:0]           in_command,
  input  logic [31:0]          in_page_address,
  output logic                 out_valid,
  output logic [2:0]           out_status,
  output logic [31:0]          out_granted_address,
  output logic [7:0]           out_reference_count,
  output logic                 out_page_released
);

  localparam int unsigned PW = $clog2(NUM_PAGES);
  localparam int unsigned FW = PW + 1;
  localparam logic [COUNT_BITS-1:0] CNT_MAX  = {COUNT_BITS{1'b1}};
  localparam logic [COUNT_BITS-1:0] CNT_ONE  = COUNT_BITS'(1);
  localparam logic [PW-1:0]         IDX_LAST = PW'(NUM_PAGES - 1);
  localparam logic [FW-1:0]         FILL_MAX = FW'(NUM_PAGES);

  // configuration
  logic [31:0] base_r, top_r, first_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      base_r  <= BASE_RST;
      top_r   <= TOP_RST;
      first_r <= FIRST_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_BASE:  base_r  <= cfg_wdata;
        REG_TOP:   top_r   <= cfg_wdata;
        REG_FIRST: first_r <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // transaction capture
  logic [1:0]  cmd_r;
  logic [31:0] addr_r;

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      cmd_r  <= in_command;
      addr_r <= in_page_address;
    end
  end

  // address decode
  logic [31:0] off;
  logic [32:0] pnum;
  logic        in_range, bad_nxt;
  logic [PW-1:0] idx_nxt;

  always_comb begin
    off      = addr_r - base_r;
    pnum     = {1'b0, off} >> PAGE_SHIFT;
    in_range = (addr_r >= base_r) && (addr_r < top_r) && (pnum < 33'(NUM_PAGES));
    idx_nxt  = pnum[PW-1:0];
    bad_nxt  = !in_range;
    if (cmd_r == CMD_FREE) begin
      bad_nxt = !in_range || (addr_r[PAGE_SHIFT-1:0] != '0) || (addr_r < first_r);
    end
  end

  logic [PW-1:0] idx_r;
  logic          bad_r;

  always_ff @(posedge clk) begin
    if (cmd.decode) begin
      idx_r <= idx_nxt;
      bad_r <= bad_nxt;
    end
  end

  // stack fill and clearing sweep
  logic [FW-1:0] fill_r;
  logic [PW-1:0] clr_r;

  assign sts.clr_last = (clr_r == IDX_LAST);

  // memories
  logic [COUNT_BITS-1:0] cnt_mem [NUM_PAGES];
  logic [PW-1:0]         stk_mem [NUM_PAGES];
  logic [COUNT_BITS-1:0] cnt_rd_r;
  logic [PW-1:0]         stk_rd_r;

  logic                  cw_en;
  logic [PW-1:0]         cw_addr;
  logic [COUNT_BITS-1:0] cw_data;
  logic                  push, pop;

  always_ff @(posedge clk) begin
    if (cw_en) begin
      cnt_mem[cw_addr] <= cw_data;
    end
    if (cmd.decode) begin
      cnt_rd_r <= cnt_mem[idx_nxt];
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      stk_mem[fill_r[PW-1:0]] <= idx_r;
    end
    if (cmd.decode) begin
      stk_rd_r <= stk_mem[fill_r[PW-1:0] - PW'(1)];
    end
  end

  // execute
  logic [2:0]            st_nxt;
  logic [31:0]           gnt_nxt;
  logic [COUNT_BITS-1:0] cnt_nxt;
  logic                  rel_nxt;
  logic [63:0]           gofs;
  logic [COUNT_BITS-1:0] dec, inc;

  always_comb begin
    gofs    = 64'(stk_rd_r) << PAGE_SHIFT;
    dec     = cnt_rd_r - CNT_ONE;
    inc     = cnt_rd_r + CNT_ONE;
    st_nxt  = ST_OK;
    gnt_nxt = '0;
    cnt_nxt = '0;
    rel_nxt = 1'b0;
    cw_en   = 1'b0;
    cw_addr = idx_r;
    cw_data = '0;
    push    = 1'b0;
    pop     = 1'b0;
    if (cmd.clr_en) begin
      cw_en   = 1'b1;
      cw_addr = clr_r;
    end else if (cmd.exec) begin
      case (cmd_r)
        CMD_ALLOC: begin
          if (fill_r == '0) begin
            st_nxt = ST_EMPTY;
          end else begin
            pop     = 1'b1;
            cw_en   = 1'b1;
            cw_addr = stk_rd_r;
            cw_data = CNT_ONE;
            cnt_nxt = CNT_ONE;
            gnt_nxt = base_r + gofs[31:0];
          end
        end
        CMD_FREE: begin
          if (bad_r) begin
            st_nxt = ST_BADADDR;
          end else if (cnt_rd_r == '0) begin
            st_nxt = ST_UNDERFLOW;
          end else begin
            cw_en   = 1'b1;
            cw_data = dec;
            cnt_nxt = dec;
            if ((dec == '0) && (fill_r < FILL_MAX)) begin
              push    = 1'b1;
              rel_nxt = 1'b1;
            end
          end
        end
        CMD_INCREF: begin
          if (bad_r) begin
            st_nxt = ST_BADADDR;
          end else if (cnt_rd_r == CNT_MAX) begin
            st_nxt  = ST_SATURATED;
            cnt_nxt = cnt_rd_r;
          end else begin
            cw_en   = 1'b1;
            cw_data = inc;
            cnt_nxt = inc;
          end
        end
        CMD_QUERY: begin
          if (bad_r) begin
            st_nxt = ST_BADADDR;
          end else begin
            cnt_nxt = cnt_rd_r;
          end
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fill_r <= '0;
      clr_r  <= '0;
    end else begin
      if (cmd.clr_en) begin
        clr_r <= clr_r + PW'(1);
      end
      if (push) begin
        fill_r <= fill_r + FW'(1);
      end else if (pop) begin
        fill_r <= fill_r - FW'(1);
      end
    end
  end

  // result registers
  logic        valid_r;
  logic [2:0]  status_r;
  logic [31:0] gnt_r;
  logic [7:0]  refcnt_r;
  logic        rel_r;
  logic [31:0] cnt_wide;

  assign cnt_wide = 32'(cnt_nxt);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= cmd.exec;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.exec) begin
      status_r <= st_nxt;
      gnt_r    <= gnt_nxt;
      refcnt_r <= cnt_wide[7:0];
      rel_r    <= rel_nxt;
    end
  end

  assign out_valid           = valid_r;
  assign out_status          = status_r;
  assign out_granted_address = gnt_r;
  assign out_reference_count = refcnt_r;
  assign out_page_released   = rel_r;

endmodule

/* src/pgalloc_chk.sv */
// ----------------------------------------------------------------------------
// pgalloc_chk
// Port-level checks of the page allocator, bound to the top level.
// ----------------------------------------------------------------------------
module pgalloc_chk
  import pgalloc_pkg::*;
(
  input logic                 clk,
  input logic                 rst_n,
  input logic                 start,
  input logic                 busy,
  input logic [1:0]           in_command,
  input logic [31:0]          in_page_address,
  input logic                 out_valid,
  input logic [2:0]           out_status,
  input logic [31:0]          out_granted_address,
  input logic [7:0]           out_reference_count,
  input logic                 out_page_released,
  input logic                 cfg_we,
  input logic [CFG_IDX_W-1:0] cfg_index,
  input logic [31:0]          cfg_wdata
);

  // an accepted transaction makes the block busy
  a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |=> busy)
    else $error("not busy after accepted transaction");

  // one result per transaction, never back to back
  a_single_strobe: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |=> !out_valid)
    else $error("result strobe held two cycles");

  // a result appears only once the transaction has left the engine
  a_valid_idle: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (!busy && $past(busy)))
    else $error("result while busy");

  // a released page is a free that brought the count to zero
  a_release: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_page_released) |->
      (out_status == ST_OK && out_reference_count == 8'd0 &&
       out_granted_address == 32'd0))
    else $error("bad release result");

  // failed commands grant nothing
  a_fail_nogrant: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_status != ST_OK) |-> (out_granted_address == 32'd0))
    else $error("address granted on failure");

endmodule

bind page_allocator_with_refcounts_core pgalloc_chk u_chk (.*);

/* bench/testbench.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the page allocator core: drives alloc, free,
// add-reference and query commands across several address windows, predicts
// every result from an internal copy of the count table and free stack, and
// compares each strobed result field by field.
// ----------------------------------------------------------------------------
module testbench;
  import pgalloc_pkg::*;

  localparam int unsigned NUM_PG    = 32768;
  localparam int unsigned PG_SHIFT  = 12;
  localparam logic [31:0] PG_SIZE   = 32'h0000_1000;
  localparam logic [31:0] PG_MASK   = 32'h0000_0FFF;
  localparam logic [7:0]  COUNT_MAX = 8'hFF;
  // an index with no register behind it, writes there must be dropped
  localparam logic [CFG_IDX_W-1:0] REG_NONE = 2'd3;

  typedef struct packed {
    logic [2:0]  status;
    logic [31:0] granted_address;
    logic [7:0]  reference_count;
    logic        page_released;
  } pg_result_t;

  // --------------------------------------------------------------------------
  // scoreboard: own copy of the allocator state, predicts and compares
  // --------------------------------------------------------------------------
  class pg_scoreboard;
    logic [31:0] base_addr;
    logic [31:0] top_addr;
    logic [31:0] first_usable;
    logic [7:0]  ref_counts [NUM_PG];
    logic [14:0] free_pages [NUM_PG];
    int unsigned stack_fill;
    int unsigned peak_fill;
    int unsigned accepted;
    int unsigned compared;
    int unsigned mismatches;
    pg_result_t  awaited [$];

    function new();
      base_addr    = BASE_RST;
      top_addr     = TOP_RST;
      first_usable = FIRST_RST;
      foreach (ref_counts[i]) ref_counts[i] = '0;
      foreach (free_pages[i]) free_pages[i] = '0;
      stack_fill = 0;
      peak_fill  = 0;
      accepted   = 0;
      compared   = 0;
      mismatches = 0;
    endfunction

    function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [31:0] value);
      case (idx)
        REG_BASE:  base_addr    = value;
        REG_TOP:   top_addr     = value;
        REG_FIRST: first_usable = value;
        default: ;
      endcase
    endfunction

    // page number of an address inside the window covered by the count table
    function bit page_in_window(logic [31:0] addr, output int unsigned idx);
      logic [31:0] offset;
      idx = 0;
      if (addr < base_addr || addr >= top_addr) return 1'b0;
      offset = addr - base_addr;
      if ((offset >> PG_SHIFT) >= NUM_PG) return 1'b0;
      idx = offset >> PG_SHIFT;
      return 1'b1;
    endfunction

    // accepted transaction: update the state and queue its result
    function pg_result_t note(logic [1:0] cmd, logic [31:0] addr);
      pg_result_t  r;
      int unsigned idx;
      bit          hit;
      r   = '0;
      r.status = ST_OK;
      hit = page_in_window(addr, idx);
      case (cmd)
        CMD_ALLOC: begin
          if (stack_fill == 0) begin
            r.status = ST_EMPTY;
          end else begin
            stack_fill--;
            idx = free_pages[stack_fill];
            ref_counts[idx]   = 8'd1;
            r.reference_count = 8'd1;
            r.granted_address = base_addr + (32'(idx) << PG_SHIFT);
          end
        end
        CMD_FREE: begin
          if ((addr & PG_MASK) != 0 || addr < first_usable || !hit) begin
            r.status = ST_BADADDR;
          end else if (ref_counts[idx] == 0) begin
            r.status = ST_UNDERFLOW;
          end else begin
            ref_counts[idx]--;
            r.reference_count = ref_counts[idx];
            if (ref_counts[idx] == 0 && stack_fill < NUM_PG) begin
              free_pages[stack_fill] = idx[14:0];
              stack_fill++;
              if (stack_fill > peak_fill) peak_fill = stack_fill;
              r.page_released = 1'b1;
            end
          end
        end
        CMD_INCREF: begin
          if (!hit) begin
            r.status = ST_BADADDR;
          end else if (ref_counts[idx] == COUNT_MAX) begin
            r.status          = ST_SATURATED;
            r.reference_count = ref_counts[idx];
          end else begin
            ref_counts[idx]++;
            r.reference_count = ref_counts[idx];
          end
        end
        default: begin
          if (!hit) r.status = ST_BADADDR;
          else r.reference_count = ref_counts[idx];
        end
      endcase
      awaited.push_back(r);
      accepted++;
      return r;
    endfunction

    task report(string msg);
      if (mismatches < 40) $display("testbench: mismatch at result %0d: %s", compared, msg);
      mismatches++;
    endtask

    task check(pg_result_t got);
      pg_result_t want;
      if (awaited.size() == 0) begin
        report($sformatf("result with nothing outstanding, status %0d", got.status));
        return;
      end
      want = awaited.pop_front();
      compared++;
      if (got.status !== want.status)
        report($sformatf("status %0d, wanted %0d", got.status, want.status));
      if (got.granted_address !== want.granted_address)
        report($sformatf("granted address %h, wanted %h",
                         got.granted_address, want.granted_address));
      if (got.reference_count !== want.reference_count)
        report($sformatf("reference count %0d, wanted %0d",
                         got.reference_count, want.reference_count));
      if (got.page_released !== want.page_released)
        report($sformatf("page released %b, wanted %b",
                         got.page_released, want.page_released));
    endtask
  endclass

  // --------------------------------------------------------------------------
  // clock, reset and block inputs, all known from time zero
  // --------------------------------------------------------------------------
  logic                 clk = 1'b0;
  logic                 rst_n = 1'b0;
  logic                 start = 1'b0;
  logic [1:0]           in_command = CMD_ALLOC;
  logic [31:0]          in_page_address = '0;
  logic                 cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index = REG_BASE;
  logic [31:0]          cfg_wdata = '0;
  logic                 busy;
  logic                 out_valid;
  logic [2:0]           out_status;
  logic [31:0]          out_granted_address;
  logic [7:0]           out_reference_count;
  logic                 out_page_released;

  pg_scoreboard sb = new();
  bit           no_gaps = 1'b0;
  int unsigned  reg_settings = 1;

  always begin
    #4;
    clk = 1'b1;
    #4;
    clk = 1'b0;
  end

  page_allocator_with_refcounts_core #(
    .NUM_PAGES  (NUM_PG),
    .PAGE_SHIFT (PG_SHIFT),
    .COUNT_BITS (8)
  ) u_top (
    .clk                 (clk),
    .rst_n               (rst_n),
    .start               (start),
    .busy                (busy),
    .in_command          (in_command),
    .in_page_address     (in_page_address),
    .out_valid           (out_valid),
    .out_status          (out_status),
    .out_granted_address (out_granted_address),
    .out_reference_count (out_reference_count),
    .out_page_released   (out_page_released),
    .cfg_we              (cfg_we),
    .cfg_index           (cfg_index),
    .cfg_wdata           (cfg_wdata)
  );

  // results are sampled at the edge that ends their single strobe cycle
  always @(posedge clk) begin : result_monitor
    pg_result_t seen;
    if (rst_n && out_valid === 1'b1) begin
      seen = '{out_status, out_granted_address, out_reference_count, out_page_released};
      sb.check(seen);
    end
  end

  // --------------------------------------------------------------------------
  // helpers
  // --------------------------------------------------------------------------

  // sender idle time: mostly none or a few cycles so that gaps fall on every
  // phase of the transaction (accept, decode, execute), now and then a long pause
  function automatic int unsigned pick_gap();
    int unsigned r;
    if (no_gaps) return 0;
    r = $urandom_range(0, 99);
    if (r < 45) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  function automatic logic [31:0] align_up(logic [31:0] addr);
    return (addr + PG_MASK) & ~PG_MASK;
  endfunction

  // small working set so counts, frees and pops keep meeting each other,
  // with the last table entry and the odd far page mixed in
  function automatic int unsigned hot_page();
    int unsigned r;
    r = $urandom_range(0, 19);
    if (r < 16) return $urandom_range(0, 7);
    if (r < 18) return NUM_PG - 1;
    return $urandom_range(0, NUM_PG - 1);
  endfunction

  // one command transaction; start stays high when no gap follows so that
  // back-to-back commands are offered without a bubble
  task automatic send(input logic [1:0] cmd, input logic [31:0] addr,
                      output pg_result_t want);
    int unsigned gap;
    in_command      <= cmd;
    in_page_address <= addr;
    start           <= 1'b1;
    do @(posedge clk); while (busy !== 1'b0);
    want = sb.note(cmd, addr);
    gap  = pick_gap();
    if (gap != 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  // stop offering commands and wait for every outstanding result
  task automatic drain();
    if (start) start <= 1'b0;
    while (sb.awaited.size() != 0) @(posedge clk);
  endtask

  // new address window, written only while the block is idle; the unused
  // index gets junk that must leave the registers alone
  task automatic program_regs(input logic [31:0] base, input logic [31:0] top,
                              input logic [31:0] first);
    logic [31:0] junk;
    junk = $urandom();
    cfg_we    <= 1'b1;
    cfg_index <= REG_BASE;
    cfg_wdata <= base;
    @(posedge clk);
    cfg_index <= REG_TOP;
    cfg_wdata <= top;
    @(posedge clk);
    cfg_index <= REG_NONE;
    cfg_wdata <= junk;
    @(posedge clk);
    cfg_index <= REG_FIRST;
    cfg_wdata <= first;
    @(posedge clk);
    cfg_we <= 1'b0;
    sb.write_reg(REG_BASE, base);
    sb.write_reg(REG_TOP, top);
    sb.write_reg(REG_NONE, junk);
    sb.write_reg(REG_FIRST, first);
    reg_settings++;
  endtask

  // random traffic: mostly single commands on the working set and complete
  // page lifecycles (take references, drop them all, pop, maybe free the
  // popped page), the rest boundary and junk addresses with any command
  task automatic random_run(input int unsigned n);
    pg_result_t  r;
    logic [31:0] a;
    logic [31:0] g;
    logic [1:0]  cmd;
    int unsigned stop_at;
    int unsigned pick;
    int unsigned k;
    stop_at = sb.accepted + n;
    while (sb.accepted < stop_at) begin
      // flip between idling and stretches with none at all
      if ($urandom_range(0, 19) == 0) no_gaps = ~no_gaps;
      a    = sb.base_addr + (hot_page() << PG_SHIFT);
      pick = $urandom_range(0, 99);
      if (pick < 55) begin
        k = $urandom_range(0, 99);
        if (k < 20) cmd = CMD_ALLOC;
        else if (k < 50) cmd = CMD_FREE;
        else if (k < 85) cmd = CMD_INCREF;
        else cmd = CMD_QUERY;
        if (cmd == CMD_ALLOC) begin
          a = $urandom();
        end else if (cmd == CMD_FREE) begin
          a = align_up(a);
          if ($urandom_range(0, 9) == 0) a[11:0] = 12'($urandom());
        end else if ($urandom_range(0, 3) == 0) begin
          a[11:0] = 12'($urandom());
        end
        send(cmd, a, r);
      end else if (pick < 85) begin
        a = align_up(a);
        k = $urandom_range(1, 4);
        repeat (k) send(CMD_INCREF, a, r);
        repeat (k) send(CMD_FREE, a, r);
        send(CMD_ALLOC, $urandom(), r);
        if (r.status == ST_OK && $urandom_range(0, 1) == 1) begin
          g = r.granted_address;
          send(CMD_FREE, g, r);
        end
      end else begin
        case ($urandom_range(0, 7))
          0: a = $urandom();
          1: a = sb.base_addr - 1;
          2: a = sb.top_addr;
          3: a = sb.top_addr - 1;
          4: a = sb.base_addr + (32'(NUM_PG) << PG_SHIFT);
          5: a = align_up(sb.first_usable) - PG_SIZE;
          6: a = align_up(sb.first_usable);
          default: a = ($urandom_range(0, 1) == 1) ? 32'hFFFF_FFFF : 32'h0000_0000;
        endcase
        cmd = 2'($urandom());
        send(cmd, a, r);
      end
    end
    no_gaps = 1'b0;
    drain();
  endtask

  // --------------------------------------------------------------------------
  // main sequence
  // --------------------------------------------------------------------------
  initial begin : main_sequence
    pg_result_t  r;
    logic [31:0] g;

    // reset once; the core then sweeps its count table with busy high
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed: reset window, empty stack, both table ends, bad addresses,
    // underflow, release and last-in first-out pops
    send(CMD_ALLOC, 32'h0000_0000, r);               // nothing free yet
    send(CMD_QUERY, BASE_RST, r);
    send(CMD_FREE, BASE_RST, r);                     // free at count zero
    send(CMD_INCREF, BASE_RST, r);
    send(CMD_INCREF, BASE_RST | PG_MASK, r);         // offset ignored
    send(CMD_QUERY, BASE_RST + 32'h123, r);
    send(CMD_FREE, BASE_RST + 32'h1, r);             // misaligned free
    send(CMD_FREE, BASE_RST - PG_SIZE, r);           // below first usable
    send(CMD_INCREF, TOP_RST - 32'h1, r);            // last table entry
    send(CMD_INCREF, TOP_RST, r);                    // one past the top
    send(CMD_QUERY, 32'h0000_0000, r);
    send(CMD_QUERY, 32'hFFFF_FFFF, r);
    send(CMD_INCREF, BASE_RST - 32'h1, r);
    send(CMD_FREE, BASE_RST, r);
    send(CMD_FREE, BASE_RST, r);                     // count reaches zero
    send(CMD_FREE, BASE_RST, r);
    send(CMD_FREE, TOP_RST - PG_SIZE, r);
    send(CMD_ALLOC, 32'hFFFF_FFFF, r);               // most recent free first
    send(CMD_ALLOC, 32'h5555_AAAA, r);
    send(CMD_ALLOC, 32'h0000_0000, r);               // empty again
    send(CMD_QUERY, TOP_RST - PG_SIZE, r);

    // pump one page up to the saturation limit and one step past it
    g = BASE_RST + (32'd5 << PG_SHIFT);
    repeat (256) send(CMD_INCREF, g, r);
    send(CMD_QUERY, g, r);
    send(CMD_FREE, g, r);
    drain();

    // random traffic over a range of windows, extremes included
    random_run(350);
    program_regs(32'h0000_0000, 32'hFFFF_FFFF, 32'h0000_0000);
    random_run(350);
    // tiny window at the top of the address space, popped pages wrap
    program_regs(32'hFFFF_8000, 32'hFFFF_FFFF, 32'hFFFF_C000);
    random_run(300);
    // window not page aligned, frees only above a raised floor
    program_regs(32'h1234_5678, 32'h1A34_5678, 32'h1240_0000);
    random_run(300);
    // empty window: top below base, nothing may be freed
    program_regs(32'hFFFF_FFFF, 32'h0000_0000, 32'hFFFF_FFFF);
    random_run(80);
    program_regs(BASE_RST, TOP_RST, FIRST_RST);
    random_run(190);

    // let any stray strobe show up before the verdict
    repeat (8) @(posedge clk);
    $display("testbench: %0d transactions over %0d register settings, %0d results compared",
             sb.accepted, reg_settings, sb.compared);
    $display("testbench: free stack peaked at %0d of %0d entries", sb.peak_fill, NUM_PG);
    if (sb.mismatches == 0 && sb.awaited.size() == 0) begin
      $display("testbench: done, clean");
    end else begin
      $display("testbench: done, errors");
    end
    $finish;
  end

  // watchdog: several times the slowest legal run, sweep included
  initial begin : watchdog
    #12_000_000;
    $display("testbench: done, errors");
    $finish;
  end

endmodule

/* sim.f */
src/pgalloc_pkg.sv
src/pgalloc_ctrl.sv
src/pgalloc_dp.sv
src/page_allocator_with_refcounts_core.sv
src/pgalloc_chk.sv
bench/testbench.sv
